// ===== design/cdt_pkg.sv =====
package cdt_pkg;

   // timer modes as reported on the result channel
   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_RUNNING = 2'd1,
      MODE_PAUSED  = 2'd2,
      MODE_EXPIRED = 2'd3
   } cdt_mode_type;

   // action codes; 5 to 7 are unused and ignored
   localparam logic [2:0] ACT_TICK   = 3'd0;
   localparam logic [2:0] ACT_TOGGLE = 3'd1;
   localparam logic [2:0] ACT_CLEAR  = 3'd2;
   localparam logic [2:0] ACT_INC    = 3'd3;
   localparam logic [2:0] ACT_DEC    = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_STEP = 2'd0;
   localparam logic [1:0] CSR_MIN  = 2'd1;
   localparam logic [1:0] CSR_MAX  = 2'd2;

   localparam logic [11:0] STEP_RESET = 12'd30;
   localparam logic [11:0] MIN_RESET  = 12'd30;
   localparam logic [11:0] MAX_RESET  = 12'd3600;

   localparam logic [9:0]  MS_PER_SECOND = 10'd1000;
   localparam logic [21:0] REMAIN_MAX    = 22'h3F_FFFF;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] now_ms;
   } cdt_req_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [21:0] display_ms;
      logic        alert;
   } cdt_rsp_type;

   typedef struct packed {
      logic [11:0] step_seconds;
      logic [11:0] min_seconds;
      logic [11:0] max_seconds;
   } cdt_cfg_type;

endpackage

// ===== design/cdt_step.sv =====
module cdt_step import cdt_pkg::*; #(
   parameter int DEFAULT_SECONDS = 300
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  cdt_req_type item,
   input  cdt_cfg_type cfg,
   output cdt_rsp_type result
);

   cdt_mode_type mode_ff, mode_in;
   logic [11:0]  duration_ff, duration_in;
   logic [21:0]  remaining_ff, remaining_in;
   logic [31:0]  target_ff, target_in;

   logic [31:0]        past_target;
   logic [31:0]        to_target;
   logic               reached;
   logic [21:0]        left_ms;
   logic [21:0]        duration_ms;
   logic signed [13:0] stepped;
   logic signed [13:0] clamped;
   logic [21:0]        display_ms;
   logic               alert;

   always_comb begin
      // wrap-safe: reached when now - target is non-negative as signed
      past_target = item.now_ms - target_ff;
      reached     = ~past_target[31];
      to_target   = target_ff - item.now_ms;
      left_ms     = (to_target[31:22] != 10'd0) ? REMAIN_MAX : to_target[21:0];
      duration_ms = {10'd0, duration_ff} * {12'd0, MS_PER_SECOND};

      if (item.action == ACT_INC) begin
         stepped = $signed({2'b00, duration_ff}) + $signed({2'b00, cfg.step_seconds});
      end else begin
         stepped = $signed({2'b00, duration_ff}) - $signed({2'b00, cfg.step_seconds});
      end
      clamped = stepped;
      if (clamped < $signed({2'b00, cfg.min_seconds})) begin
         clamped = $signed({2'b00, cfg.min_seconds});
      end
      if (clamped > $signed({2'b00, cfg.max_seconds})) begin
         clamped = $signed({2'b00, cfg.max_seconds});
      end

      mode_in      = mode_ff;
      duration_in  = duration_ff;
      remaining_in = remaining_ff;
      target_in    = target_ff;
      alert        = 1'b0;

      case (item.action)
         ACT_TICK: begin
            if (mode_ff == MODE_RUNNING) begin
               if (reached) begin
                  mode_in      = MODE_EXPIRED;
                  remaining_in = '0;
                  alert        = 1'b1;
               end else begin
                  remaining_in = left_ms;
               end
            end
         end
         ACT_TOGGLE: begin
            if (mode_ff == MODE_RUNNING) begin
               remaining_in = reached ? '0 : left_ms;
               mode_in      = MODE_PAUSED;
            end else if (mode_ff == MODE_PAUSED) begin
               target_in = item.now_ms + {10'd0, remaining_ff};
               mode_in   = MODE_RUNNING;
            end else begin
               remaining_in = duration_ms;
               target_in    = item.now_ms + {10'd0, duration_ms};
               mode_in      = MODE_RUNNING;
            end
         end
         ACT_CLEAR: begin
            mode_in      = MODE_IDLE;
            remaining_in = '0;
         end
         ACT_INC, ACT_DEC: begin
            if (mode_ff == MODE_IDLE) begin
               duration_in = clamped[11:0];
            end
         end
         default: begin
         end
      endcase

      display_ms = (mode_in == MODE_IDLE) ?
                   {10'd0, duration_in} * {12'd0, MS_PER_SECOND} : remaining_in;

      result.mode       = mode_in;
      result.display_ms = display_ms;
      result.alert      = alert;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         duration_ff  <= 12'(DEFAULT_SECONDS);
         remaining_ff <= '0;
         target_ff    <= '0;
      end else if (advance) begin
         mode_ff      <= mode_in;
         duration_ff  <= duration_in;
         remaining_ff <= remaining_in;
         target_ff    <= target_in;
      end
   end

endmodule

// ===== design/countdown_timer_pause_resume.sv =====
// Countdown timer with pause and resume. Each request transaction carries an
// action (tick, start/pause toggle, clear, increase, decrease) and the
// free-running millisecond uptime; each one yields exactly one response
// transaction with the new mode, the displayed milliseconds and a one-shot
// alert on the tick that expires the timer. One transaction is taken every
// cycle while req_stall is low; a request goes into the input register, then
// through the state update into the result register, which presents the
// response until it is taken. A stalled response holds the result register,
// then the input register, then stalls requests. Duration limits and step size
// are set through the csr_ port; the user must do so while the timer is quiet,
// which the block itself does not enforce. csr_ready is always high.
module countdown_timer_pause_resume import cdt_pkg::*; #(
   parameter int DEFAULT_SECONDS = 300
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  cdt_req_type req_data,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output cdt_rsp_type rsp_data,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   cdt_cfg_type cfg_ff;

   logic        in_valid_ff, in_valid_in;
   cdt_req_type in_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   cdt_rsp_type rsp_data_ff;

   logic        advance;
   logic        req_take;
   cdt_rsp_type step_result;

   // the held request moves on when the result register is free or emptying
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   cdt_step #(
      .DEFAULT_SECONDS(DEFAULT_SECONDS)
   ) u_step (
      .clock  (clock),
      .reset  (reset),
      .advance(advance),
      .item   (in_data_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   // configuration; index 3 is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_seconds <= STEP_RESET;
         cfg_ff.min_seconds  <= MIN_RESET;
         cfg_ff.max_seconds  <= MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STEP: cfg_ff.step_seconds <= csr_wdata;
            CSR_MIN:  cfg_ff.min_seconds  <= csr_wdata;
            CSR_MAX:  cfg_ff.max_seconds  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   // an alert only ever comes with the expired mode
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.alert |-> rsp_data.mode == MODE_EXPIRED)
      else $error("alert without expiry");

   // expired timer always shows zero time left
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.mode == MODE_EXPIRED |-> rsp_data.display_ms == 22'd0)
      else $error("expired timer shows time left");

   // an accepted request is held in the input register next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> in_valid_ff)
      else $error("accepted request lost");
`endif

endmodule
